@@ hw/rtl/efw_pkg.sv @@
// efw_pkg: shared types and constants of the event flag waiter unit
// holds field widths, operation and status codes, list entry and fsm types
// no dependencies
`default_nettype none

package efw_pkg;

  // field widths of the item channels
  localparam int unsigned KindW   = 3;
  localparam int unsigned TaskW   = 4;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatusW = 2;

  // operation codes
  localparam logic [KindW-1:0] KIND_SET    = 3'd0;
  localparam logic [KindW-1:0] KIND_CLEAR  = 3'd1;
  localparam logic [KindW-1:0] KIND_WAIT   = 3'd2;
  localparam logic [KindW-1:0] KIND_CANCEL = 3'd3;
  localparam logic [KindW-1:0] KIND_DELETE = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK           = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_SIGNALED = 2'd1;
  localparam logic [StatusW-1:0] ST_BLOCKED      = 2'd2;

  // resume reasons of a woken task
  localparam logic REASON_OK      = 1'b0;
  localparam logic REASON_DELETED = 1'b1;

  // one wait list entry
  typedef struct packed {
    logic [TaskW-1:0] id;
    logic [PrioW-1:0] prio;
  } efw_entry_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } efw_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/event_flag_waiter_unit.sv @@
// event_flag_waiter_unit: one rtos event object with an ordered wait list
// the wait list lives in a single synchronous memory; uses efw_pkg
// a one-hot sequencer scans, shifts and appends entries of that memory
//
// Usage: an operation item (kind, task id, priority, poll flag) enters on the
// in channel (in_valid_i / in_stall_o); one or more result items leave on the
// out channel (out_valid_o / out_stall_i), the final one marked by last_o.
// The mode register (1 auto clear, 0 manual clear) is written through
// cfg_wr_en_i / cfg_wr_data_i; the user must write it only while the block is
// idle, the block itself does not enforce this.
// Set or delete with an empty list, an auto clear set that finds the flag
// set, clear, a wait that finds the flag set or fails its poll, and reserved
// codes go straight to the result register when they are taken.
// A blocking wait and a cancel scan the list once before the result register
// is loaded, and a cancel that finds its task then shifts the list. Each woken
// waiter costs one full scan of the list for the best priority and one shift
// to close the gap; these list walks through the single memory set the rate.
// A new item is taken once the last result of the previous one sits in the
// output register.
// Reset clears the flag, the list count, the mode register and the output
// valid; the memory itself is not cleared. A stalled receiver holds the
// result in the output register and the sequencer waits before the next one.
`default_nettype none

module event_flag_waiter_unit #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_wr_en_i,
  input  logic                          cfg_wr_data_i,
  // operation items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [efw_pkg::KindW-1:0]     kind_i,
  input  logic [efw_pkg::TaskW-1:0]     task_id_i,
  input  logic [efw_pkg::PrioW-1:0]     task_priority_i,
  input  logic                          poll_only_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [efw_pkg::StatusW-1:0]   op_status_o,
  output logic                          woken_valid_o,
  output logic [efw_pkg::TaskW-1:0]     woken_task_o,
  output logic                          woken_reason_o,
  output logic                          last_o
);

  import efw_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_WAITERS);

  // control state
  efw_state_e        state_q, state_d;
  logic              auto_q;
  logic              signaled_q, signaled_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // operation context
  logic [KindW-1:0]  kind_q, kind_d;
  logic [TaskW-1:0]  id_q, id_d;
  logic [PrioW-1:0]  prio_q, prio_d;
  logic              wake_one_q, wake_one_d;
  logic              reason_q, reason_d;

  // list walk
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              found_q, found_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [PrioW-1:0]  best_prio_q, best_prio_d;
  logic [TaskW-1:0]  best_id_q, best_id_d;

  // pending result
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic               res_wvalid_q, res_wvalid_d;
  logic [TaskW-1:0]   res_task_q, res_task_d;
  logic               res_reason_q, res_reason_d;
  logic               res_last_q, res_last_d;

  // output register
  logic [StatusW-1:0] out_status_q;
  logic               out_wvalid_q;
  logic [TaskW-1:0]   out_task_q;
  logic               out_reason_q;
  logic               out_last_q;

  // memory port
  efw_entry_t        waiter_mem [MAX_WAITERS];
  efw_entry_t        rd_data_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  efw_entry_t        wr_data;

  logic              in_acc;
  logic              out_load;
  logic              walk_done;
  logic              find_mode;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign walk_done = (ptr_q == count_q) && !rd_vld_q;
  assign find_mode = (kind_q == KIND_WAIT) || (kind_q == KIND_CANCEL);

  // sequencer
  always_comb begin
    state_d      = state_q;
    signaled_d   = signaled_q;
    count_d      = count_q;
    kind_d       = kind_q;
    id_d         = id_q;
    prio_d       = prio_q;
    wake_one_d   = wake_one_q;
    reason_d     = reason_q;
    ptr_d        = ptr_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_id_d    = best_id_q;
    res_status_d = res_status_q;
    res_wvalid_d = res_wvalid_q;
    res_task_d   = res_task_q;
    res_reason_d = res_reason_q;
    res_last_d   = res_last_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = rd_idx_q - AW'(1);
    wr_data      = rd_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d       = kind_i;
          id_d         = task_id_i;
          prio_d       = task_priority_i;
          wake_one_d   = 1'b0;
          reason_d     = REASON_OK;
          ptr_d        = '0;
          found_d      = 1'b0;
          res_status_d = ST_OK;
          res_wvalid_d = 1'b0;
          res_task_d   = '0;
          res_reason_d = REASON_OK;
          res_last_d   = 1'b1;
          state_d      = S_RESP;
          case (kind_i)
            KIND_SET: begin
              if (auto_q) begin
                wake_one_d = 1'b1;
                signaled_d = 1'b1;
                if (!signaled_q && (count_q != '0)) begin
                  state_d = S_SCAN;
                end
              end else begin
                signaled_d = 1'b1;
                if (count_q != '0) begin
                  state_d = S_SCAN;
                end
              end
            end
            KIND_CLEAR: begin
              signaled_d = 1'b0;
            end
            KIND_WAIT: begin
              if (signaled_q) begin
                if (auto_q) begin
                  signaled_d = 1'b0;
                end
              end else if (poll_only_i) begin
                res_status_d = ST_NOT_SIGNALED;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_CANCEL: begin
              state_d = S_SCAN;
            end
            KIND_DELETE: begin
              signaled_d = 1'b0;
              reason_d   = REASON_DELETED;
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue reads in list order, compare the entry read last cycle
        if (ptr_q != count_q) begin
          rd_en    = 1'b1;
          ptr_d    = ptr_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[AW-1:0];
        end
        if (rd_vld_q) begin
          if (find_mode) begin
            if (!found_q && (rd_data_q.id == id_q)) begin
              found_d    = 1'b1;
              best_idx_d = rd_idx_q;
            end
          end else if (!found_q || (rd_data_q.prio < best_prio_q)) begin
            found_d     = 1'b1;
            best_idx_d  = rd_idx_q;
            best_prio_d = rd_data_q.prio;
            best_id_d   = rd_data_q.id;
          end
        end
        if (walk_done) begin
          ptr_d = CW'(best_idx_q) + CW'(1);
          if (kind_q == KIND_WAIT) begin
            state_d = S_RESP;
            if (found_q) begin
              res_status_d = ST_BLOCKED;
            end else if (count_q >= CntMax) begin
              res_status_d = ST_NOT_SIGNALED;
            end else begin
              // append the new waiter at the tail
              wr_en        = 1'b1;
              wr_addr      = count_q[AW-1:0];
              wr_data.id   = id_q;
              wr_data.prio = prio_q;
              count_d      = count_q + CW'(1);
              res_status_d = ST_BLOCKED;
            end
          end else if (kind_q == KIND_CANCEL) begin
            state_d = found_q ? S_SHIFT : S_RESP;
          end else begin
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // close the gap: entry j+1 moves to j, reads run ahead of writes
        if (ptr_q != count_q) begin
          rd_en    = 1'b1;
          ptr_d    = ptr_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[AW-1:0];
        end
        if (rd_vld_q) begin
          wr_en = 1'b1;
        end
        if (walk_done) begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
          if (!find_mode) begin
            res_status_d = ST_OK;
            res_wvalid_d = 1'b1;
            res_task_d   = best_id_q;
            res_reason_d = reason_q;
            res_last_d   = wake_one_q || (count_q == CW'(1));
          end
        end
      end

      S_RESP: begin
        if (out_load) begin
          ptr_d   = '0;
          found_d = 1'b0;
          state_d = res_last_q ? S_IDLE : S_SCAN;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      auto_q      <= 1'b0;
      signaled_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      ptr_q       <= '0;
    end else begin
      state_q     <= state_d;
      signaled_q  <= signaled_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      ptr_q       <= ptr_d;
      if (cfg_wr_en_i) begin
        auto_q <= cfg_wr_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    id_q         <= id_d;
    prio_q       <= prio_d;
    wake_one_q   <= wake_one_d;
    reason_q     <= reason_d;
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_id_q    <= best_id_d;
    res_status_q <= res_status_d;
    res_wvalid_q <= res_wvalid_d;
    res_task_q   <= res_task_d;
    res_reason_q <= res_reason_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_wvalid_q <= res_wvalid_q;
      out_task_q   <= res_task_q;
      out_reason_q <= res_reason_q;
      out_last_q   <= res_last_q;
    end
  end

  // wait list memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      waiter_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= waiter_mem[rd_addr];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign op_status_o    = out_status_q;
  assign woken_valid_o  = out_wvalid_q;
  assign woken_task_o   = out_task_q;
  assign woken_reason_o = out_reason_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/efw_checker.sv @@
// efw_checker: port-level assertions for event_flag_waiter_unit
// bound to the top level below; uses efw_pkg status codes
`default_nettype none

module efw_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [efw_pkg::StatusW-1:0]   op_status_o,
  input  logic                          woken_valid_o,
  input  logic [efw_pkg::TaskW-1:0]     woken_task_o,
  input  logic                          woken_reason_o,
  input  logic                          last_o
);

  import efw_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(op_status_o)
      && $stable(woken_valid_o) && $stable(woken_task_o)
      && $stable(woken_reason_o) && $stable(last_o))
    else $error("stalled result item changed");

  // an item that wakes nobody carries zero task and reason
  a_no_wake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !woken_valid_o |-> (woken_task_o == '0) && !woken_reason_o)
    else $error("empty wake fields not zero");

  // failed or blocked waits give one single item
  a_wait_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((op_status_o == ST_NOT_SIGNALED) || (op_status_o == ST_BLOCKED))
      |-> last_o && !woken_valid_o)
    else $error("wait result not a single item");

  // woken tasks only come with status ok
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_valid_o |-> (op_status_o == ST_OK))
    else $error("woken task with bad status");

  // more results follow a non-final item, so no new operation is taken
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |-> in_stall_o)
    else $error("operation taken before last result");

endmodule

bind event_flag_waiter_unit efw_checker u_efw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .op_status_o    (op_status_o),
  .woken_valid_o  (woken_valid_o),
  .woken_task_o   (woken_task_o),
  .woken_reason_o (woken_reason_o),
  .last_o         (last_o)
);

`default_nettype wire

@@ sim/tb_event_flag_waiter_unit.sv @@
// tb_event_flag_waiter_unit: self-checking testbench of the event flag waiter unit
// drives operation items with random gaps, predicts every result item and compares it
// depends on efw_pkg and event_flag_waiter_unit
`default_nettype none

module tb_event_flag_waiter_unit;
  import efw_pkg::*;

  localparam int unsigned ListDepth    = 16;
  localparam int unsigned SettleCycles = 2 * ListDepth + 8;
  localparam int unsigned CycleLimit   = 1_000_000;

  // operation codes the block ignores
  localparam logic [KindW-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KindW-1:0] KIND_RSVD_LAST  = 3'd7;

  // one result item as the block should present it
  typedef struct {
    logic [StatusW-1:0] status;
    logic               woken;
    logic [TaskW-1:0]   woken_id;
    logic               reason;
    logic               last_item;
  } op_result_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               cfg_wr_en_i     = 1'b0;
  logic               cfg_wr_data_i   = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i          = '0;
  logic [TaskW-1:0]   task_id_i       = '0;
  logic [PrioW-1:0]   task_priority_i = '0;
  logic               poll_only_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [StatusW-1:0] op_status_o;
  logic               woken_valid_o;
  logic [TaskW-1:0]   woken_task_o;
  logic               woken_reason_o;
  logic               last_o;

  // predicted event object state
  logic               ev_auto_clear = 1'b0;
  logic               ev_signaled   = 1'b0;
  logic [TaskW-1:0]   ev_wait_id   [ListDepth];
  logic [PrioW-1:0]   ev_wait_prio [ListDepth];
  int unsigned        ev_wait_cnt   = 0;

  op_result_t         awaited_results[$];
  int unsigned        error_count   = 0;
  int unsigned        ops_accepted  = 0;
  int unsigned        cycle_count   = 0;
  bit                 quiet_run     = 1'b0;

  event_flag_waiter_unit #(
    .MAX_WAITERS(ListDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .poll_only_i    (poll_only_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .op_status_o    (op_status_o),
    .woken_valid_o  (woken_valid_o),
    .woken_task_o   (woken_task_o),
    .woken_reason_o (woken_reason_o),
    .last_o         (last_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_run && ($urandom_range(99) < 9);
  end

  // ---------------------------------------------------------------------------
  // prediction of the event object
  // ---------------------------------------------------------------------------

  function automatic int find_waiter_slot(input logic [TaskW-1:0] id);
    for (int i = 0; i < ev_wait_cnt; i++) begin
      if (ev_wait_id[i] == id) return i;
    end
    return -1;
  endfunction

  // close the gap left by a leaving waiter, keeping arrival order
  function automatic void drop_waiter(input int pos);
    for (int i = pos; i + 1 < ev_wait_cnt; i++) begin
      ev_wait_id[i]   = ev_wait_id[i + 1];
      ev_wait_prio[i] = ev_wait_prio[i + 1];
    end
    ev_wait_cnt--;
  endfunction

  // lowest priority value wins, earliest arrival among equals
  function automatic logic [TaskW-1:0] take_best_waiter();
    int best;
    logic [TaskW-1:0] id;
    best = 0;
    for (int i = 1; i < ev_wait_cnt; i++) begin
      if (ev_wait_prio[i] < ev_wait_prio[best]) best = i;
    end
    id = ev_wait_id[best];
    drop_waiter(best);
    return id;
  endfunction

  function automatic void expect_result(input logic [StatusW-1:0] st, input logic woken,
                                        input logic [TaskW-1:0] id, input logic why,
                                        input logic fin);
    op_result_t r;
    r.status    = st;
    r.woken     = woken;
    r.woken_id  = id;
    r.reason    = why;
    r.last_item = fin;
    awaited_results.push_back(r);
  endfunction

  // wake up to limit waiters best first, or give one empty result
  function automatic void release_waiters(input logic [StatusW-1:0] st, input logic why,
                                          input int unsigned limit);
    int unsigned n_wake;
    logic [TaskW-1:0] id;
    n_wake = (ev_wait_cnt < limit) ? ev_wait_cnt : limit;
    if (n_wake == 0) begin
      expect_result(st, 1'b0, '0, REASON_OK, 1'b1);
    end else begin
      for (int unsigned n = 0; n < n_wake; n++) begin
        id = take_best_waiter();
        expect_result(st, 1'b1, id, why, n == n_wake - 1);
      end
    end
  endfunction

  function automatic void predict_event_op(input logic [KindW-1:0] k,
                                           input logic [TaskW-1:0] id,
                                           input logic [PrioW-1:0] prio, input logic poll);
    case (k)
      KIND_SET: begin
        if (ev_auto_clear) begin
          if (ev_signaled) begin
            release_waiters(ST_OK, REASON_OK, 0);
          end else begin
            ev_signaled = 1'b1;
            release_waiters(ST_OK, REASON_OK, 1);
          end
        end else begin
          ev_signaled = 1'b1;
          release_waiters(ST_OK, REASON_OK, ListDepth);
        end
      end
      KIND_CLEAR: begin
        ev_signaled = 1'b0;
        expect_result(ST_OK, 1'b0, '0, REASON_OK, 1'b1);
      end
      KIND_WAIT: begin
        if (ev_signaled) begin
          if (ev_auto_clear) ev_signaled = 1'b0;
          expect_result(ST_OK, 1'b0, '0, REASON_OK, 1'b1);
        end else if (poll) begin
          expect_result(ST_NOT_SIGNALED, 1'b0, '0, REASON_OK, 1'b1);
        end else if (find_waiter_slot(id) >= 0) begin
          // already listed: stored priority stays
          expect_result(ST_BLOCKED, 1'b0, '0, REASON_OK, 1'b1);
        end else if (ev_wait_cnt >= ListDepth) begin
          expect_result(ST_NOT_SIGNALED, 1'b0, '0, REASON_OK, 1'b1);
        end else begin
          ev_wait_id[ev_wait_cnt]   = id;
          ev_wait_prio[ev_wait_cnt] = prio;
          ev_wait_cnt++;
          expect_result(ST_BLOCKED, 1'b0, '0, REASON_OK, 1'b1);
        end
      end
      KIND_CANCEL: begin
        if (find_waiter_slot(id) >= 0) drop_waiter(find_waiter_slot(id));
        expect_result(ST_OK, 1'b0, '0, REASON_OK, 1'b1);
      end
      KIND_DELETE: begin
        ev_signaled = 1'b0;
        release_waiters(ST_OK, REASON_DELETED, ListDepth);
      end
      default: begin
        expect_result(ST_OK, 1'b0, '0, REASON_OK, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    op_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result item with none expected: status %0d woken %0d task %0d",
               op_status_o, woken_valid_o, woken_task_o);
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        compare_field("op_status", 8'(exp_r.status), 8'(op_status_o));
        compare_field("woken_valid", 8'(exp_r.woken), 8'(woken_valid_o));
        compare_field("woken_task", 8'(exp_r.woken_id), 8'(woken_task_o));
        compare_field("woken_reason", 8'(exp_r.reason), 8'(woken_reason_o));
        compare_field("last", 8'(exp_r.last_item), 8'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item driving
  // ---------------------------------------------------------------------------

  // present one item, hold it until taken, then predict its results
  task automatic send_op(input logic [KindW-1:0] k, input logic [TaskW-1:0] id,
                         input logic [PrioW-1:0] prio, input logic poll);
    while (!quiet_run && ($urandom_range(99) < 9)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    task_id_i       <= id;
    task_priority_i <= prio;
    poll_only_i     <= poll;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_event_op(k, id, prio, poll);
    if (k <= KIND_DELETE) ops_accepted++;
  endtask

  // stop sending and wait for every outstanding result item
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // mode writes only once the block has gone quiet
  task automatic set_event_mode(input logic mode);
    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= mode;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    ev_auto_clear = mode;
  endtask

  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return PrioW'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // flag handling with an empty list, manual mode
  task automatic test_poll_and_flag();
    set_event_mode(1'b0);
    send_op(KIND_WAIT, 4'd3, 8'd0, 1'b1);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    send_op(KIND_WAIT, 4'd3, 8'd0, 1'b1);
    send_op(KIND_WAIT, 4'd4, 8'd9, 1'b0);
    send_op(KIND_CLEAR, 4'd0, 8'd0, 1'b0);
    send_op(KIND_WAIT, 4'd15, 8'd255, 1'b1);
  endtask

  // manual set wakes everyone still listed, best first, after a repeat wait and cancels
  task automatic test_wake_order();
    send_op(KIND_WAIT, 4'd1, 8'd200, 1'b0);
    send_op(KIND_WAIT, 4'd2, 8'd0, 1'b0);
    send_op(KIND_WAIT, 4'd3, 8'd0, 1'b0);
    send_op(KIND_WAIT, 4'd4, 8'd255, 1'b0);
    send_op(KIND_WAIT, 4'd1, 8'd0, 1'b0);
    send_op(KIND_CANCEL, 4'd3, 8'd0, 1'b0);
    send_op(KIND_CANCEL, 4'd9, 8'd0, 1'b0);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    send_op(KIND_CLEAR, 4'd0, 8'd0, 1'b0);
  endtask

  // auto-reset: at most one waiter per set, the flag is taken by the next wait
  task automatic test_auto_clear();
    set_event_mode(1'b1);
    send_op(KIND_WAIT, 4'd5, 8'd10, 1'b0);
    send_op(KIND_WAIT, 4'd6, 8'd10, 1'b0);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    send_op(KIND_WAIT, 4'd5, 8'd10, 1'b0);
    send_op(KIND_WAIT, 4'd7, 8'd10, 1'b1);
  endtask

  // delete releases all with reason deleted; object stays usable, reserved codes follow
  task automatic test_delete_and_unknown();
    send_op(KIND_WAIT, 4'd8, 8'd1, 1'b0);
    send_op(KIND_DELETE, 4'd0, 8'd0, 1'b0);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++) begin
      send_op(KindW'(k), 4'd15, 8'd255, 1'b1);
    end
  endtask

  // every task id listed, then a set releases all or, in auto mode, one, and a delete the rest
  task automatic test_full_list(input logic mode);
    logic [TaskW-1:0] ids [ListDepth];
    logic [TaskW-1:0] tmp;
    int j;
    set_event_mode(mode);
    send_op(KIND_CLEAR, 4'd0, 8'd0, 1'b0);
    for (int i = 0; i < ListDepth; i++) ids[i] = TaskW'(i);
    for (int i = ListDepth - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = ids[i];
      ids[i]  = ids[j];
      ids[j]  = tmp;
    end
    for (int i = 0; i < ListDepth; i++) begin
      send_op(KIND_WAIT, ids[i], PrioW'($urandom_range(3) * 85), 1'b0);
    end
    send_op(KIND_WAIT, ids[$urandom_range(ListDepth - 1)], 8'd0, 1'b0);
    send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
    send_op(KIND_DELETE, 4'd0, 8'd0, 1'b0);
  endtask

  // bursts of waits, maybe a cancel, closed by a set, delete, clear or wait, mixed with noise
  task automatic test_random_traffic(input logic mode, input int unsigned n_ops,
                                     input bit quiet);
    int unsigned start;
    int unsigned pick;
    set_event_mode(mode);
    quiet_run = quiet;
    start     = ops_accepted;
    while (ops_accepted - start < n_ops) begin
      if ($urandom_range(99) < 65) begin
        repeat ($urandom_range(1, 8)) begin
          send_op(KIND_WAIT, TaskW'($urandom_range(15)), pick_prio(),
                  $urandom_range(99) < 10);
        end
        if ($urandom_range(1)) send_op(KIND_CANCEL, TaskW'($urandom_range(15)), 8'd0, 1'b0);
        pick = $urandom_range(99);
        if (pick < 50)      send_op(KIND_SET, 4'd0, 8'd0, 1'b0);
        else if (pick < 70) send_op(KIND_DELETE, 4'd0, 8'd0, 1'b0);
        else if (pick < 85) send_op(KIND_CLEAR, 4'd0, 8'd0, 1'b0);
        else                send_op(KIND_WAIT, TaskW'($urandom_range(15)), pick_prio(), 1'b0);
      end else begin
        send_op(KindW'($urandom_range(7)), TaskW'($urandom_range(15)),
                PrioW'($urandom_range(255)), $urandom_range(1));
      end
    end
    quiet_run = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_poll_and_flag();
    test_wake_order();
    test_auto_clear();
    test_delete_and_unknown();
    test_full_list(1'b1);
    test_full_list(1'b0);
    test_random_traffic(1'b0, 20, 1'b0);
    test_random_traffic(1'b1, 20, 1'b0);
    test_random_traffic(1'b0, 20, 1'b1);
    test_random_traffic(1'b1, 20, 1'b0);
    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
